FILE: sv/pu_pkg.sv
// Shared types, widths and the factorial table for the permutation unranking block.
`default_nettype none
package pu_pkg;

   localparam int RANK_W = 64;
   localparam int ELEM_W = 4;
   localparam int SIZE_W = 5;

   localparam logic [SIZE_W-1:0] PERM_SIZE_RESET = 5'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SCAN
   } state_type;

   // n! for n up to 20, the largest factorial that fits 64 bits
   function automatic logic [RANK_W-1:0] fact_lut(input logic [SIZE_W-1:0] n);
      logic [RANK_W-1:0] f;
      case (n)
         5'd0:    f = 64'd1;
         5'd1:    f = 64'd1;
         5'd2:    f = 64'd2;
         5'd3:    f = 64'd6;
         5'd4:    f = 64'd24;
         5'd5:    f = 64'd120;
         5'd6:    f = 64'd720;
         5'd7:    f = 64'd5040;
         5'd8:    f = 64'd40320;
         5'd9:    f = 64'd362880;
         5'd10:   f = 64'd3628800;
         5'd11:   f = 64'd39916800;
         5'd12:   f = 64'd479001600;
         5'd13:   f = 64'd6227020800;
         5'd14:   f = 64'd87178291200;
         5'd15:   f = 64'd1307674368000;
         5'd16:   f = 64'd20922789888000;
         5'd17:   f = 64'd355687428096000;
         5'd18:   f = 64'd6402373705728000;
         5'd19:   f = 64'd121645100408832000;
         5'd20:   f = 64'd2432902008176640000;
         default: f = 64'd1;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

FILE: sv/pu_reduce.sv
// Bit-serial restoring remainder: rank modulo a factorial, one rank bit per cycle.
`default_nettype none
module pu_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pu_pkg::RANK_W-1:0]   rank,
   input  logic [pu_pkg::RANK_W-1:0]   modulus,
   output logic                        done,
   output logic [pu_pkg::RANK_W-1:0]   remainder
);
   import pu_pkg::*;

   localparam int CNT_W = $clog2(RANK_W);

   logic [RANK_W-1:0] shift_ff, shift_in;
   logic [RANK_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [RANK_W:0]   trial;
   logic [RANK_W:0]   diff;
   logic              fits;

   // shift in the next rank bit and try one subtraction
   always_comb begin
      trial = {rem_ff, shift_ff[RANK_W-1]};
      diff  = trial - {1'b0, modulus};
      fits  = (trial >= {1'b0, modulus});
   end

   // advance the shift registers and the bit counter
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = rank;
         rem_in   = '0;
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[RANK_W-2:0], 1'b0};
         rem_in   = fits ? diff[RANK_W-1:0] : trial[RANK_W-1:0];
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RANK_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: sv/permutation_unrank.sv
// Top level: Lehmer-code permutation unranking, one element result per position.
//
//   channel   ports                                   direction
//   request   start, busy, req_rank                   in  (taken on start & !busy)
//   response  rsp_valid, rsp_element, rsp_last        out (one-cycle strobe)
//   config    csr_valid, csr_ready, csr_data          in  (perm_size, always ready)
//
// An item holds busy through the bit-serial remainder unit and the load of the
// scan, then per position through a step for each mask bit walked and the emit.
// Picking element e walks e bits; the picks of a permutation sum to S*(S-1)/2.
// Each element strobes in the cycle after its emit; reset is synchronous and
// restores perm_size to 8. Results cannot be held off; each shows for one cycle.
`default_nettype none
module permutation_unrank #(
   parameter int MAX_ELEMS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [pu_pkg::RANK_W-1:0]   req_rank,
   output logic                        rsp_valid,
   output logic [pu_pkg::ELEM_W-1:0]   rsp_element,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pu_pkg::SIZE_W-1:0]   csr_data
);
   import pu_pkg::*;

   localparam int PW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ELEMS);

   state_type              state_ff, state_in;
   logic [SIZE_W-1:0]      perm_size_ff;
   logic [SIZE_W-1:0]      size_eff;
   logic [RANK_W-1:0]      modulus;
   logic [RANK_W-1:0]      weight;
   logic [RANK_W-1:0]      rem_ff;
   logic [SIZE_W-1:0]      pos_ff;
   logic [PW-1:0]          ptr_ff;
   logic [MAX_ELEMS-1:0]   unused_ff;
   logic                   rsp_valid_ff;
   logic [ELEM_W-1:0]      rsp_element_ff;
   logic                   rsp_last_ff;
   logic                   red_done;
   logic [RANK_W-1:0]      red_rem;
   logic                   accept;
   logic                   load_scan;
   logic                   scanning;
   logic                   hit;
   logic                   fits;
   logic                   emit;
   logic                   skip;

   // clamp the size to 1..MAX_ELEMS
   always_comb begin
      if (perm_size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (perm_size_ff > MAX_SIZE) begin
         size_eff = MAX_SIZE;
      end else begin
         size_eff = perm_size_ff;
      end
   end

   assign modulus = fact_lut(size_eff);
   assign weight  = fact_lut(pos_ff);

   pu_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .rank      (req_rank),
      .modulus   (modulus),
      .done      (red_done),
      .remainder (red_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (red_done) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (emit && pos_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state decodes
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      accept    = start && (state_ff == ST_IDLE);
      load_scan = (state_ff == ST_REDUCE) && red_done;
      scanning  = (state_ff == ST_SCAN);
      hit       = unused_ff[ptr_ff];
      fits      = (rem_ff >= weight);
      emit      = scanning && hit && !fits;
      skip      = scanning && !(hit && !fits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         perm_size_ff <= PERM_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit;
         if (csr_valid) perm_size_ff <= csr_data;
      end
   end

   // walk the mask: drop a weight for each unused element passed, emit on the first that stays
   always_ff @(posedge clock) begin
      if (load_scan) begin
         rem_ff    <= red_rem;
         pos_ff    <= size_eff - 1'b1;
         ptr_ff    <= '0;
         unused_ff <= '1;
      end else if (emit) begin
         unused_ff[ptr_ff] <= 1'b0;
         ptr_ff            <= '0;
         pos_ff            <= pos_ff - 1'b1;
      end else if (skip) begin
         if (hit) rem_ff <= rem_ff - weight;
         ptr_ff <= ptr_ff + 1'b1;
      end
      if (emit) begin
         rsp_element_ff <= ELEM_W'(ptr_ff);
         rsp_last_ff    <= (pos_ff == '0);
      end
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
`default_nettype wire
